/* rtl/core/crb_pkg.sv */
// Shared types and constants of the comb bank reverb core.
package crb_pkg;

  localparam int NUM_LINES  = 8;
  localparam int NUM_STAGES = 8;

  localparam int LINE_LEN [NUM_LINES] = '{347, 113, 37, 59, 73, 89, 97, 101};

  // Per-line feedback gains, unsigned Q1.16 (0.4 + 0.1 * line).
  localparam logic [16:0] FB_Q16 [NUM_LINES] = '{
    17'd26214, 17'd32768, 17'd39322, 17'd45875,
    17'd52429, 17'd58982, 17'd65536, 17'd72090
  };

  localparam logic [15:0] ROOM_SIZE_RST = 16'd19661;
  localparam logic [15:0] DAMPING_RST   = 16'd32768;
  localparam logic [15:0] WET_LEVEL_RST = 16'd19661;
  localparam logic [15:0] DRY_LEVEL_RST = 16'd45875;

  typedef enum logic [1:0] {
    REG_ROOM_SIZE = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_WET_LEVEL = 2'd2,
    REG_DRY_LEVEL = 2'd3
  } crb_reg_t;

  // Pipeline control shared by the comb lines and the output mixer.
  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [NUM_STAGES:1]   ld;
  } crb_ctl_t;

endpackage

/* rtl/core/crb_line.sv */
// One comb delay line: circular buffer, tap and feedback products, write-back.
module crb_line import crb_pkg::*; #(
  parameter int J  = 0,
  parameter int SW = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  crb_ctl_t             ctl,
  input  logic [16:0]          g,
  input  logic signed [15:0]   x2,
  output logic signed [SW-1:0] tap
);

  localparam int LEN = LINE_LEN[J];
  localparam int AW  = $clog2(LEN);
  localparam logic signed [SW+17:0] HALF = (SW+18)'(32768);

  logic signed [SW-1:0]  mem [LEN];
  logic [AW-1:0]         pos;
  logic                  filled;
  logic [AW-1:0]         addr1;
  logic [AW-1:0]         addr2;
  logic                  fill1;
  logic signed [SW-1:0]  rd1;
  logic [16:0]           coef;
  logic [33:0]           coef_full;
  logic signed [SW-1:0]  dm;
  logic signed [SW+17:0] prod_g;
  logic signed [SW+17:0] prod_c;
  logic signed [SW+17:0] rnd_g;
  logic signed [SW+17:0] rnd_c;
  logic signed [SW+2:0]  wsum;
  logic signed [SW-1:0]  wr_val;

  assign coef_full = 34'(FB_Q16[J]) * 34'(g) + 34'd32768;

  always_ff @(posedge clk) begin
    coef <= coef_full[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
    end else if (ctl.rd) begin
      if (pos == AW'(LEN - 1)) begin
        pos    <= '0;
        filled <= 1'b1;
      end else begin
        pos <= pos + AW'(1);
      end
    end
  end

  // Entries are only trusted once the pointer has gone around the line once.
  assign dm = fill1 ? rd1 : '0;

  assign rnd_g = prod_g + HALF;
  assign rnd_c = prod_c + HALF;
  assign wsum  = (SW+3)'(x2) + (SW+3)'($signed(rnd_c[SW+17:16]));

  always_comb begin
    if ((&wsum[SW+2:SW-1]) || !(|wsum[SW+2:SW-1])) begin
      wr_val = wsum[SW-1:0];
    end else if (wsum[SW+2]) begin
      wr_val = {1'b1, {(SW-1){1'b0}}};
    end else begin
      wr_val = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      rd1   <= mem[pos];
      fill1 <= filled;
      addr1 <= pos;
    end
    if (ctl.ld[2]) begin
      prod_g <= (SW+18)'(dm) * (SW+18)'($signed({1'b0, g}));
      prod_c <= (SW+18)'(dm) * (SW+18)'($signed({1'b0, coef}));
      addr2  <= addr1;
    end
    if (ctl.wr) begin
      mem[addr2] <= wr_val;
    end
    if (ctl.ld[3]) begin
      tap <= rnd_g[SW+15:16];
    end
  end

endmodule

/* rtl/core/crb_mix.sv */
// Tap summation, room scaling and wet/dry output mix with saturation.
module crb_mix import crb_pkg::*; #(
  parameter int SW = 20
) (
  input  logic                 clk,
  input  crb_ctl_t             ctl,
  input  logic [15:0]          room_size,
  input  logic [15:0]          wet_level,
  input  logic [15:0]          dry_level,
  input  logic signed [15:0]   x2,
  input  logic                 last2,
  input  logic signed [SW-1:0] taps [NUM_LINES],
  output logic signed [15:0]   sample_out,
  output logic                 last_out
);

  localparam logic signed [SW+19:0] HALF_R = (SW+20)'(32768);
  localparam logic signed [SW+20:0] HALF_M = (SW+21)'(32768);

  logic signed [15:0]    x3, x4, x5;
  logic                  last3, last4, last5, last6, last7;
  logic signed [SW+2:0]  acc;
  logic signed [SW+2:0]  acc_sum;
  logic signed [SW+19:0] proom;
  logic signed [SW+19:0] proom_r;
  logic signed [SW+2:0]  wr;
  logic signed [32:0]    xd6, xd7;
  logic signed [SW+19:0] pw;
  logic signed [SW+20:0] mix_sum;
  logic signed [SW+4:0]  mix_r;
  logic signed [15:0]    y_sat;

  always_comb begin
    acc_sum = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      acc_sum = acc_sum + (SW+3)'(taps[i]);
    end
  end

  assign proom_r = proom + HALF_R;
  assign mix_sum = (SW+21)'(pw) + (SW+21)'(xd7) + HALF_M;
  assign mix_r   = mix_sum[SW+20:16];

  always_comb begin
    if ((&mix_r[SW+4:15]) || !(|mix_r[SW+4:15])) begin
      y_sat = mix_r[15:0];
    end else if (mix_r[SW+4]) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      x3    <= x2;
      last3 <= last2;
    end
    if (ctl.ld[4]) begin
      acc   <= acc_sum;
      x4    <= x3;
      last4 <= last3;
    end
    if (ctl.ld[5]) begin
      proom <= (SW+20)'(acc) * (SW+20)'($signed({1'b0, room_size}));
      x5    <= x4;
      last5 <= last4;
    end
    if (ctl.ld[6]) begin
      wr    <= proom_r[SW+18:16];
      xd6   <= 33'(x5) * 33'($signed({1'b0, dry_level}));
      last6 <= last5;
    end
    if (ctl.ld[7]) begin
      pw    <= (SW+20)'(wr) * (SW+20)'($signed({1'b0, wet_level}));
      xd7   <= xd6;
      last7 <= last6;
    end
    if (ctl.ld[8]) begin
      sample_out <= y_sat;
      last_out   <= last7;
    end
  end

endmodule

/* rtl/core/comb_bank_reverb_core.sv */
// Comb bank reverb core: eight parallel comb lines feeding a wet/dry mixer.
// Each input transaction reaches its output transaction through the register stages.
// Throughput is one sample per cycle while the output is not stalled; each of the 8 register
// stages has its own enable, so a stall at the output only holds stages that are full.
// Reset clears stage valids, line pointers, line fill flags and restores register defaults.
// Line memories are not swept; a line reads as zero until its pointer first wraps.
module comb_bank_reverb_core import crb_pkg::*; #(
  parameter int STORE_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] sample_out
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]                  room_size;
  logic [15:0]                  damping_amount;
  logic [15:0]                  wet_level;
  logic [15:0]                  dry_level;
  logic [16:0]                  g;
  logic [NUM_STAGES:1]          v;
  logic [NUM_STAGES:1]          ld;
  crb_ctl_t                     ctl;
  logic signed [15:0]           x1, x2;
  logic                         last1, last2;
  logic signed [STORE_WIDTH-1:0] taps [NUM_LINES];
  logic signed [15:0]           y;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_size      <= ROOM_SIZE_RST;
      damping_amount <= DAMPING_RST;
      wet_level      <= WET_LEVEL_RST;
      dry_level      <= DRY_LEVEL_RST;
    end else if (cfg_we) begin
      case (crb_reg_t'(cfg_index))
        REG_ROOM_SIZE: room_size      <= cfg_data;
        REG_DAMPING:   damping_amount <= cfg_data;
        REG_WET_LEVEL: wet_level      <= cfg_data;
        REG_DRY_LEVEL: dry_level      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign g = 17'd65536 - 17'(damping_amount);

  always_comb begin
    ld[NUM_STAGES] = !v[NUM_STAGES] || m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = ld[1];
  assign ctl.rd = s_axis_tvalid && ld[1];
  assign ctl.wr = v[2] && ld[3];
  assign ctl.ld = ld;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x1    <= $signed(s_axis_tdata);
      last1 <= s_axis_tlast;
    end
    if (ld[2]) begin
      x2    <= x1;
      last2 <= last1;
    end
  end

  for (genvar j = 0; j < NUM_LINES; j++) begin : g_line
    crb_line #(
      .J  (j),
      .SW (STORE_WIDTH)
    ) u_line (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .g   (g),
      .x2  (x2),
      .tap (taps[j])
    );
  end

  crb_mix #(
    .SW (STORE_WIDTH)
  ) u_mix (
    .clk        (clk),
    .ctl        (ctl),
    .room_size  (room_size),
    .wet_level  (wet_level),
    .dry_level  (dry_level),
    .x2         (x2),
    .last2      (last2),
    .taps       (taps),
    .sample_out (y),
    .last_out   (m_axis_tlast)
  );

  assign m_axis_tvalid = v[NUM_STAGES];
  assign m_axis_tdata  = y;

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_ready_passes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output side is ready");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    (v[1] && !ld[1]) |-> (v[2] && v[NUM_STAGES]))
    else $error("stage held without a full stage ahead of it");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    ctl.wr |=> !(ctl.wr && $stable(x2) && !$past(ld[2]))
      || ld[2])
    else $error("comb line written twice for one transaction");

endmodule
